// ----- src/ibpa_pkg.sv -----
// Shared types, codes and result builders for the inode block placement allocator.
// No dependencies; every other file imports this package.
package ibpa_pkg;

    // used-block map word geometry
    localparam int WORD_W   = 16;
    localparam int WORD_LSB = 4;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_START  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LIMIT = 1'd1;
    localparam logic [CFG_DATA_W-1:0] DATA_START_RST  = 9'd5;
    localparam logic [CFG_DATA_W-1:0] BLOCK_LIMIT_RST = 9'd256;

    // request types
    localparam logic REQ_FILE       = 1'b0;
    localparam logic REQ_STANDALONE = 1'b1;

    // result roles
    localparam logic [2:0] ROLE_DIRECT = 3'd0;
    localparam logic [2:0] ROLE_SINGLE = 3'd1;
    localparam logic [2:0] ROLE_DOUBLE = 3'd2;
    localparam logic [2:0] ROLE_ROOT   = 3'd3;
    localparam logic [2:0] ROLE_SECOND = 3'd4;

    // error codes
    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_NO_FREE = 2'd1;
    localparam logic [1:0] ERR_TOO_BIG = 2'd2;

    typedef struct packed {
        logic req_type;
        logic new_file;
    } in_item_t;

    typedef struct packed {
        logic [7:0] block_number;
        logic [2:0] role;
        logic [6:0] inner_slot;
        logic [6:0] outer_slot;
        logic [1:0] error_code;
        logic       last;
    } out_item_t;

    // scanner status toward the sequencer
    typedef struct packed {
        logic done;
        logic found;
    } scan_rsp_t;

    function automatic out_item_t mk_result(logic [7:0] blk, logic [2:0] role,
                                            logic [6:0] inner, logic [6:0] outer,
                                            logic last);
        out_item_t r;
        r.block_number = blk;
        r.role         = role;
        r.inner_slot   = inner;
        r.outer_slot   = outer;
        r.error_code   = ERR_OK;
        r.last         = last;
        return r;
    endfunction

    function automatic out_item_t mk_error(logic [1:0] code);
        out_item_t r;
        r            = '0;
        r.error_code = code;
        r.last       = 1'b1;
        return r;
    endfunction

endpackage

// ----- src/ibpa_map.sv -----
// Used-block map: word-wide synchronous memory with a registered read port.
// Per-word valid flops make a never-written word read as all free. Uses ibpa_pkg.
module ibpa_map #(
    parameter int WORDS = 16,
    parameter int AW    = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [ibpa_pkg::WORD_W-1:0] rd_data,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [ibpa_pkg::WORD_W-1:0] wr_data
);
    import ibpa_pkg::*;

    logic [WORD_W-1:0] used_mem [WORDS];
    logic [WORDS-1:0]  valid_reg;
    logic [WORD_W-1:0] rd_word_reg;
    logic              rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            used_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_word_reg <= used_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

// ----- src/ibpa_scan.sv -----
// First-fit scanner: walks map words from data_start, claims the first free block.
// Drives ibpa_map's ports; uses ibpa_pkg.
module ibpa_scan #(
    parameter int NUM_BLOCKS = 256,
    parameter int AW         = 4,
    parameter int BW         = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ibpa_pkg::CFG_DATA_W-1:0] data_start,
    input  logic [ibpa_pkg::CFG_DATA_W-1:0] block_limit,
    output logic                          rd_en,
    output logic [AW-1:0]                 rd_addr,
    input  logic [ibpa_pkg::WORD_W-1:0]   rd_data,
    output logic                          wr_en,
    output logic [AW-1:0]                 wr_addr,
    output logic [ibpa_pkg::WORD_W-1:0]   wr_data,
    output ibpa_pkg::scan_rsp_t           rsp,
    output logic [BW-1:0]                 blk
);
    import ibpa_pkg::*;

    localparam int NW = $clog2(NUM_BLOCKS + 1);
    localparam int CW = (NW > CFG_DATA_W) ? NW : CFG_DATA_W;

    typedef enum logic [1:0] {SC_IDLE, SC_READ, SC_EVAL} sc_state_t;

    sc_state_t           state_reg;
    logic [AW-1:0]       word_reg;
    logic [AW-1:0]       first_word_reg;
    logic [AW-1:0]       last_word_reg;
    logic [WORD_LSB-1:0] lo_reg;
    logic [WORD_LSB-1:0] hi_reg;
    scan_rsp_t           rsp_reg;
    logic [BW-1:0]       blk_reg;

    logic [CW-1:0]       start_w;
    logic [CW-1:0]       end_w;
    logic [CW-1:0]       last_bit;
    logic                empty;
    logic [WORD_W-1:0]   cand;
    logic                hit;
    logic [WORD_LSB-1:0] pos;

    always_comb begin
        start_w  = CW'(data_start);
        end_w    = (CW'(block_limit) < CW'(NUM_BLOCKS)) ? CW'(block_limit) : CW'(NUM_BLOCKS);
        empty    = start_w >= end_w;
        last_bit = end_w - CW'(1);
    end

    // free bits inside [start, end) within the current word, lowest wins
    always_comb begin
        hit = 1'b0;
        pos = '0;
        for (int j = 0; j < WORD_W; j++) begin
            cand[j] = !rd_data[j]
                && ((word_reg != first_word_reg) || (WORD_LSB'(j) >= lo_reg))
                && ((word_reg != last_word_reg) || (WORD_LSB'(j) <= hi_reg));
        end
        for (int j = WORD_W - 1; j >= 0; j--) begin
            if (cand[j]) begin
                hit = 1'b1;
                pos = WORD_LSB'(j);
            end
        end
    end

    assign rd_en   = (state_reg == SC_READ);
    assign rd_addr = word_reg;
    assign wr_en   = (state_reg == SC_EVAL) && hit;
    assign wr_addr = word_reg;
    assign wr_data = rd_data | (WORD_W'(1) << pos);
    assign rsp     = rsp_reg;
    assign blk     = blk_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SC_IDLE;
            rsp_reg   <= '0;
        end else begin
            rsp_reg.done <= 1'b0;
            case (state_reg)
                SC_IDLE: begin
                    if (start) begin
                        if (empty) begin
                            rsp_reg.done  <= 1'b1;
                            rsp_reg.found <= 1'b0;
                        end else begin
                            word_reg       <= AW'(start_w >> WORD_LSB);
                            first_word_reg <= AW'(start_w >> WORD_LSB);
                            last_word_reg  <= AW'(last_bit >> WORD_LSB);
                            lo_reg         <= start_w[WORD_LSB-1:0];
                            hi_reg         <= last_bit[WORD_LSB-1:0];
                            state_reg      <= SC_READ;
                        end
                    end
                end
                SC_READ: begin
                    state_reg <= SC_EVAL;
                end
                SC_EVAL: begin
                    if (hit) begin
                        rsp_reg.done  <= 1'b1;
                        rsp_reg.found <= 1'b1;
                        blk_reg       <= BW'({word_reg, pos});
                        state_reg     <= SC_IDLE;
                    end else if (word_reg == last_word_reg) begin
                        rsp_reg.done  <= 1'b1;
                        rsp_reg.found <= 1'b0;
                        state_reg     <= SC_IDLE;
                    end else begin
                        word_reg  <= word_reg + AW'(1);
                        state_reg <= SC_READ;
                    end
                end
                default: begin
                    state_reg <= SC_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- src/ibpa_seq.sv -----
// Request sequencer: file index and indirect flags, allocation order, result register.
// Starts scans in ibpa_scan; uses ibpa_pkg.
module ibpa_seq #(
    parameter int DIRECT_SLOTS       = 12,
    parameter int POINTERS_PER_BLOCK = 128,
    parameter int BW                 = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ibpa_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ibpa_pkg::out_item_t  m_data,
    output logic                 scan_start,
    input  ibpa_pkg::scan_rsp_t  scan_rsp,
    input  logic [BW-1:0]        scan_blk
);
    import ibpa_pkg::*;

    localparam int MAX_FILE = DIRECT_SLOTS + POINTERS_PER_BLOCK
                              + POINTERS_PER_BLOCK * POINTERS_PER_BLOCK;
    localparam int IDX_W    = $clog2(MAX_FILE + 1);
    localparam int PW       = $clog2(POINTERS_PER_BLOCK);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_t;
    typedef enum logic [2:0] {
        STEP_DATA, STEP_STANDALONE, STEP_ROOT_S, STEP_ROOT_D, STEP_SECOND
    } step_t;
    typedef enum logic [2:0] {
        NX_DONE, NX_DONE_INC, NX_ROOT_S, NX_ROOT_D, NX_SECOND
    } next_t;

    state_t          state_reg;
    step_t           step_reg;
    next_t           nxt_reg;
    out_item_t       pend_reg;
    out_item_t       out_data_reg;
    logic            out_valid_reg;
    logic            scan_start_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [PW-1:0]   dinner_reg;
    logic [PW-1:0]   douter_reg;
    logic            single_reg;
    logic            root_reg;
    logic            halted_reg;
    logic [1:0]      held_err_reg;

    logic            in_direct;
    logic            in_single;
    logic            need_second;
    logic            out_free;
    logic [7:0]      blk8;
    logic [IDX_W-1:0] idx_eff;

    always_comb begin
        in_direct   = idx_reg < IDX_W'(DIRECT_SLOTS);
        in_single   = !in_direct && (idx_reg < IDX_W'(DIRECT_SLOTS + POINTERS_PER_BLOCK));
        need_second = (dinner_reg == '0);
        out_free    = !out_valid_reg || m_ready;
        blk8        = 8'(scan_blk);
        idx_eff     = s_data.new_file ? '0 : idx_reg;
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = out_valid_reg;
    assign m_data     = out_data_reg;
    assign scan_start = scan_start_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            step_reg       <= STEP_DATA;
            nxt_reg        <= NX_DONE;
            pend_reg       <= '0;
            out_data_reg   <= '0;
            out_valid_reg  <= 1'b0;
            scan_start_reg <= 1'b0;
            idx_reg        <= '0;
            dinner_reg     <= '0;
            douter_reg     <= '0;
            single_reg     <= 1'b0;
            root_reg       <= 1'b0;
            halted_reg     <= 1'b0;
            held_err_reg   <= ERR_OK;
        end else begin
            scan_start_reg <= 1'b0;
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (halted_reg) begin
                            pend_reg  <= mk_error(held_err_reg);
                            nxt_reg   <= NX_DONE;
                            state_reg <= ST_EMIT;
                        end else if (s_data.req_type == REQ_STANDALONE) begin
                            step_reg       <= STEP_STANDALONE;
                            scan_start_reg <= 1'b1;
                            state_reg      <= ST_SCAN;
                        end else begin
                            if (s_data.new_file) begin
                                idx_reg    <= '0;
                                dinner_reg <= '0;
                                douter_reg <= '0;
                                single_reg <= 1'b0;
                                root_reg   <= 1'b0;
                            end
                            if (idx_eff >= IDX_W'(MAX_FILE)) begin
                                pend_reg     <= mk_error(ERR_TOO_BIG);
                                halted_reg   <= 1'b1;
                                held_err_reg <= ERR_TOO_BIG;
                                nxt_reg      <= NX_DONE;
                                state_reg    <= ST_EMIT;
                            end else begin
                                step_reg       <= STEP_DATA;
                                scan_start_reg <= 1'b1;
                                state_reg      <= ST_SCAN;
                            end
                        end
                    end
                end
                ST_SCAN: begin
                    if (scan_rsp.done) begin
                        state_reg <= ST_EMIT;
                        if (!scan_rsp.found) begin
                            pend_reg     <= mk_error(ERR_NO_FREE);
                            halted_reg   <= 1'b1;
                            held_err_reg <= ERR_NO_FREE;
                            nxt_reg      <= NX_DONE;
                        end else begin
                            case (step_reg)
                                STEP_STANDALONE: begin
                                    pend_reg <= mk_result(blk8, ROLE_DIRECT, '0, '0, 1'b1);
                                    nxt_reg  <= NX_DONE;
                                end
                                STEP_DATA: begin
                                    if (in_direct) begin
                                        pend_reg <= mk_result(blk8, ROLE_DIRECT,
                                                              7'(idx_reg), '0, 1'b1);
                                        nxt_reg  <= NX_DONE_INC;
                                    end else if (in_single) begin
                                        pend_reg <= mk_result(blk8, ROLE_SINGLE,
                                            7'(idx_reg - IDX_W'(DIRECT_SLOTS)), '0, single_reg);
                                        nxt_reg  <= single_reg ? NX_DONE_INC : NX_ROOT_S;
                                    end else begin
                                        pend_reg <= mk_result(blk8, ROLE_DOUBLE, 7'(dinner_reg),
                                            7'(douter_reg), root_reg && !need_second);
                                        if (!root_reg) begin
                                            nxt_reg <= NX_ROOT_D;
                                        end else if (need_second) begin
                                            nxt_reg <= NX_SECOND;
                                        end else begin
                                            nxt_reg <= NX_DONE_INC;
                                        end
                                    end
                                end
                                STEP_ROOT_S: begin
                                    single_reg <= 1'b1;
                                    pend_reg   <= mk_result(blk8, ROLE_ROOT,
                                                            7'(DIRECT_SLOTS), '0, 1'b1);
                                    nxt_reg    <= NX_DONE_INC;
                                end
                                STEP_ROOT_D: begin
                                    root_reg <= 1'b1;
                                    pend_reg <= mk_result(blk8, ROLE_ROOT,
                                                          7'(DIRECT_SLOTS + 1), '0, !need_second);
                                    nxt_reg  <= need_second ? NX_SECOND : NX_DONE_INC;
                                end
                                STEP_SECOND: begin
                                    pend_reg <= mk_result(blk8, ROLE_SECOND, '0,
                                                          7'(douter_reg), 1'b1);
                                    nxt_reg  <= NX_DONE_INC;
                                end
                                default: begin
                                    pend_reg <= mk_error(ERR_NO_FREE);
                                    nxt_reg  <= NX_DONE;
                                end
                            endcase
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        out_data_reg  <= pend_reg;
                        out_valid_reg <= 1'b1;
                        case (nxt_reg)
                            NX_DONE: begin
                                state_reg <= ST_IDLE;
                            end
                            NX_DONE_INC: begin
                                idx_reg <= idx_reg + IDX_W'(1);
                                // double region walks (outer, inner) alongside the index
                                if (!in_direct && !in_single) begin
                                    if (dinner_reg == PW'(POINTERS_PER_BLOCK - 1)) begin
                                        dinner_reg <= '0;
                                        douter_reg <= douter_reg + PW'(1);
                                    end else begin
                                        dinner_reg <= dinner_reg + PW'(1);
                                    end
                                end
                                state_reg <= ST_IDLE;
                            end
                            NX_ROOT_S: begin
                                step_reg       <= STEP_ROOT_S;
                                scan_start_reg <= 1'b1;
                                state_reg      <= ST_SCAN;
                            end
                            NX_ROOT_D: begin
                                step_reg       <= STEP_ROOT_D;
                                scan_start_reg <= 1'b1;
                                state_reg      <= ST_SCAN;
                            end
                            NX_SECOND: begin
                                step_reg       <= STEP_SECOND;
                                scan_start_reg <= 1'b1;
                                state_reg      <= ST_SCAN;
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- src/inode_block_placement_allocator_top.sv -----
// Top level of the inode block placement allocator: configuration registers and wiring.
// Instantiates ibpa_map, ibpa_scan and ibpa_seq; uses ibpa_pkg.
//
// Usage:
//   s_valid/s_ready/s_data carry requests (file block or standalone block).
//   m_valid/m_ready/m_data carry one to three results per request; the final
//   one of each request has last set. cfg_valid/cfg_ready/cfg_index/cfg_data
//   write data_start (index 0) and block_limit (index 1); cfg_ready is always
//   high and writes belong in idle periods.
// Flow:
//   Each allocation is a first-fit scan over the used map, held as 16-bit
//   words in a memory with a registered read port; a scan reads and then
//   evaluates each word it visits, up to ceil(NUM_BLOCKS/16) words. A
//   result goes from the scanner into a pending register and then into
//   the output register; a halted request emits its error without a scan.
//   One request is in flight at a time; a new one is taken while the last
//   result still waits in the output register.
// Reset: map reads as all free at once (per-word valid flops, no clearing
//   pass), file index and flags clear, configuration returns to 5 and 256.
// Stall: a held result stays on m_data; further results of the same
//   request wait behind it.
module inode_block_placement_allocator_top #(
    parameter int NUM_BLOCKS         = 256,
    parameter int DIRECT_SLOTS       = 12,
    parameter int POINTERS_PER_BLOCK = 128
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  ibpa_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output ibpa_pkg::out_item_t             m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ibpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ibpa_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ibpa_pkg::*;

    localparam int WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = $clog2(NUM_BLOCKS);

    logic [CFG_DATA_W-1:0] data_start_reg;
    logic [CFG_DATA_W-1:0] block_limit_reg;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              scan_start;
    scan_rsp_t         scan_rsp;
    logic [BW-1:0]     scan_blk;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_start_reg  <= DATA_START_RST;
            block_limit_reg <= BLOCK_LIMIT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DATA_START: begin
                    data_start_reg <= cfg_data;
                end
                CFG_BLOCK_LIMIT: begin
                    block_limit_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    ibpa_map #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    ibpa_scan #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .AW         (AW),
        .BW         (BW)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (scan_start),
        .data_start  (data_start_reg),
        .block_limit (block_limit_reg),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rsp         (scan_rsp),
        .blk         (scan_blk)
    );

    ibpa_seq #(
        .DIRECT_SLOTS       (DIRECT_SLOTS),
        .POINTERS_PER_BLOCK (POINTERS_PER_BLOCK),
        .BW                 (BW)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .scan_start (scan_start),
        .scan_rsp   (scan_rsp),
        .scan_blk   (scan_blk)
    );

endmodule

// ----- src/ibpa_checker.sv -----
// Port-level checks for the allocator top, attached by the bind at the end.
// Uses ibpa_pkg for result codes.
module ibpa_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input ibpa_pkg::out_item_t m_data
);
    import ibpa_pkg::*;

    logic seen_err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_err_reg <= 1'b0;
        end else if (m_valid && m_ready && (m_data.error_code != ERR_OK)) begin
            seen_err_reg <= 1'b1;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another is in progress");

    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.error_code != ERR_OK) |->
            m_data.last && (m_data.block_number == '0) && (m_data.role == ROLE_DIRECT)
            && (m_data.inner_slot == '0) && (m_data.outer_slot == '0))
        else $error("error result not final or carries fields");

    a_halted: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_err_reg && m_valid |-> m_data.error_code != ERR_OK)
        else $error("allocation after an error transfer");

    a_second: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.role == ROLE_SECOND) |-> (m_data.inner_slot == '0) && m_data.last)
        else $error("second-level result malformed");

endmodule

bind inode_block_placement_allocator_top ibpa_checker u_ibpa_checker (.*);

// ----- test/tb.sv -----
// Self-checking testbench for inode_block_placement_allocator_top.
// Needs ibpa_pkg and the allocator RTL. A built-in predictor tracks the used-block map
// and file index and checks every result transfer, in order.
`timescale 1ns / 1ps

module tb;
    import ibpa_pkg::*;

    localparam int NUM_BLK      = 256;
    localparam int DIRECT       = 12;
    localparam int PTRS         = 128;
    localparam int DBL_FIRST    = DIRECT + PTRS;
    localparam int MAX_FILE     = DIRECT + PTRS + PTRS * PTRS;
    localparam int DEEP_STOP    = 40;
    localparam int DRAIN_CYCLES = 3 * (2 * (NUM_BLK / WORD_W) + 2);
    localparam int QUIET_LIMIT  = 5000;

    typedef enum {
        RUN_OUT_EMPTY_RANGE,
        RUN_OUT_FULL_RANGE,
        RUN_OUT_SINGLE_ROOT
    } run_out_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // allocator state as the predictor sees it
    bit [NUM_BLK-1:0]      blk_used = '0;
    logic [CFG_DATA_W-1:0] start_reg = DATA_START_RST;
    logic [CFG_DATA_W-1:0] limit_reg = BLOCK_LIMIT_RST;
    int unsigned           file_idx = 0;
    bit                    single_root_done = 1'b0;
    bit                    double_root_done = 1'b0;
    bit                    stopped = 1'b0;
    logic [1:0]            stop_code = ERR_OK;
    out_item_t             expected_results[$];

    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    int mismatches = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int unsigned peak_idx = 0;
    int quiet_cycles = 0;

    inode_block_placement_allocator_top #(
        .NUM_BLOCKS         (NUM_BLK),
        .DIRECT_SLOTS       (DIRECT),
        .POINTERS_PER_BLOCK (PTRS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= dst_idle_pct);
    end

    // ---------------- predictor ----------------

    function automatic int scan_end();
        return (limit_reg < NUM_BLK) ? int'(limit_reg) : NUM_BLK;
    endfunction

    function automatic bit grab_block(output logic [7:0] blk);
        int top_blk = scan_end();
        blk = '0;
        for (int b = start_reg; b < top_blk; b++) begin
            if (!blk_used[b]) begin
                blk_used[b] = 1'b1;
                blk = 8'(b);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic int free_in_range();
        int cnt = 0;
        int top_blk = scan_end();
        for (int b = start_reg; b < top_blk; b++) begin
            if (!blk_used[b])
                cnt++;
        end
        return cnt;
    endfunction

    // block_limit that leaves exactly n free blocks above data_start
    function automatic int limit_for_free(int n);
        int seen = 0;
        for (int b = start_reg; b < NUM_BLK; b++) begin
            if (!blk_used[b]) begin
                if (seen == n)
                    return b;
                seen++;
            end
        end
        return NUM_BLK;
    endfunction

    function automatic void add_expected(logic [7:0] blk, logic [2:0] role, int unsigned inner,
                                         int unsigned outer, logic last);
        out_item_t r;
        r.block_number = blk;
        r.role         = role;
        r.inner_slot   = 7'(inner);
        r.outer_slot   = 7'(outer);
        r.error_code   = ERR_OK;
        r.last         = last;
        expected_results.push_back(r);
    endfunction

    function automatic void add_error(logic [1:0] code);
        out_item_t r;
        r            = '0;
        r.error_code = code;
        r.last       = 1'b1;
        expected_results.push_back(r);
    endfunction

    function automatic void halt_with(logic [1:0] code);
        stopped   = 1'b1;
        stop_code = code;
        add_error(code);
    endfunction

    function automatic void place_request(in_item_t it);
        logic [7:0]  data_blk;
        logic [7:0]  meta_blk;
        int unsigned d;
        int unsigned outer;
        int unsigned inner;
        bit          want_root;
        bit          want_second;
        if (stopped) begin
            add_error(stop_code);
            return;
        end
        if (it.req_type == REQ_STANDALONE) begin
            // standalone results carry role and slots of zero
            if (!grab_block(data_blk))
                halt_with(ERR_NO_FREE);
            else
                add_expected(data_blk, ROLE_DIRECT, 0, 0, 1'b1);
            return;
        end
        if (it.new_file) begin
            file_idx         = 0;
            single_root_done = 1'b0;
            double_root_done = 1'b0;
        end
        if (file_idx >= MAX_FILE) begin
            halt_with(ERR_TOO_BIG);
            return;
        end
        if (!grab_block(data_blk)) begin
            halt_with(ERR_NO_FREE);
            return;
        end
        if (file_idx < DIRECT) begin
            add_expected(data_blk, ROLE_DIRECT, file_idx, 0, 1'b1);
        end else if (file_idx < DBL_FIRST) begin
            add_expected(data_blk, ROLE_SINGLE, file_idx - DIRECT, 0, single_root_done);
            if (!single_root_done) begin
                if (!grab_block(meta_blk)) begin
                    halt_with(ERR_NO_FREE);
                    return;
                end
                single_root_done = 1'b1;
                add_expected(meta_blk, ROLE_ROOT, DIRECT, 0, 1'b1);
            end
        end else begin
            d           = file_idx - DBL_FIRST;
            outer       = d / PTRS;
            inner       = d % PTRS;
            want_root   = !double_root_done;
            want_second = (inner == 0);
            add_expected(data_blk, ROLE_DOUBLE, inner, outer, !(want_root || want_second));
            if (want_root) begin
                if (!grab_block(meta_blk)) begin
                    halt_with(ERR_NO_FREE);
                    return;
                end
                double_root_done = 1'b1;
                add_expected(meta_blk, ROLE_ROOT, DIRECT + 1, 0, !want_second);
            end
            if (want_second) begin
                if (!grab_block(meta_blk)) begin
                    halt_with(ERR_NO_FREE);
                    return;
                end
                add_expected(meta_blk, ROLE_SECOND, 0, outer, 1'b1);
            end
        end
        file_idx++;
        if (file_idx > peak_idx)
            peak_idx = file_idx;
    endfunction

    // ---------------- result check ----------------

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %p", $time, m_data);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("block_number", want.block_number, m_data.block_number);
                check_field("role", want.role, m_data.role);
                check_field("inner_slot", want.inner_slot, m_data.inner_slot);
                check_field("outer_slot", want.outer_slot, m_data.outer_slot);
                check_field("error_code", want.error_code, m_data.error_code);
                check_field("last", want.last, m_data.last);
            end
        end
    end

    // watchdog: counts cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------- drivers ----------------

    task automatic send_req(input logic req, input logic nf);
        in_item_t it;
        it.req_type = req;
        it.new_file = nf;
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = it;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        place_request(it);
    endtask

    // stop sending and let every outstanding result drain
    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_DATA_START)
            start_reg = val;
        else
            limit_reg = val;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic rand_req(int standalone_pct);
        return ($urandom_range(99) < standalone_pct) ? REQ_STANDALONE : REQ_FILE;
    endfunction

    // ---------------- tests ----------------

    task automatic test_directed();
        src_idle_pct = 25;
        dst_idle_pct = 80;
        send_req(REQ_STANDALONE, 1'b0);
        send_req(REQ_STANDALONE, 1'b1);   // new_file has no effect here
        send_req(REQ_FILE, 1'b1);
        for (int i = 1; i < DIRECT; i++)
            send_req(REQ_FILE, 1'b0);
        send_req(REQ_FILE, 1'b0);         // first single-indirect block brings its root
        send_req(REQ_STANDALONE, 1'b1);   // file index untouched
        send_req(REQ_FILE, 1'b0);
        send_req(REQ_FILE, 1'b0);
        send_req(REQ_FILE, 1'b1);         // restart in the middle of the single range
        send_req(REQ_FILE, 1'b0);
    endtask

    task automatic test_window();
        int n;
        write_reg(CFG_DATA_START, 9'd255);
        send_req(REQ_STANDALONE, 1'b0);   // topmost block
        write_reg(CFG_DATA_START, 9'($urandom_range(120, 180)));
        write_reg(CFG_BLOCK_LIMIT, start_reg + 9'd50);
        n = 0;
        while (n < 20 && free_in_range() >= 3 && !stopped) begin
            send_req(rand_req(30), ($urandom_range(9) == 0));
            n++;
        end
    endtask

    // one long file that walks through direct and single-indirect slots
    task automatic test_deep_file();
        src_idle_pct = 80;
        dst_idle_pct = 25;
        write_reg(CFG_DATA_START, 9'd0);
        write_reg(CFG_BLOCK_LIMIT, 9'd256);
        send_req(REQ_FILE, 1'b1);
        while (file_idx < DEEP_STOP && !stopped) begin
            if (file_idx == 24 || $urandom_range(19) == 0)
                wait_idle();
            if ($urandom_range(9) == 0 && free_in_range() > DEEP_STOP - file_idx + 40)
                send_req(REQ_STANDALONE, 1'($urandom_range(1)));
            else
                send_req(REQ_FILE, 1'b0);
        end
    endtask

    task automatic test_exhaustion();
        run_out_t kind;
        src_idle_pct = 0;
        dst_idle_pct = 0;
        kind = run_out_t'($urandom_range(2));
        for (int i = 0; i < 8; i++)
            send_req(REQ_FILE, 1'b0);
        case (kind)
            RUN_OUT_EMPTY_RANGE: begin
                write_reg(CFG_DATA_START, 9'd256);
                send_req(REQ_STANDALONE, 1'b0);
            end
            RUN_OUT_FULL_RANGE: begin
                write_reg(CFG_BLOCK_LIMIT, 9'(limit_for_free(0)));
                send_req(rand_req(50), 1'b0);
            end
            default: begin
                send_req(REQ_FILE, 1'b1);
                for (int i = 1; i < DIRECT; i++)
                    send_req(REQ_FILE, 1'b0);
                // data block fits, its single-indirect root does not
                write_reg(CFG_BLOCK_LIMIT, 9'(limit_for_free(1)));
                send_req(REQ_FILE, 1'b0);
            end
        endcase
    endtask

    // after an error every request repeats the held code, whatever the setup
    task automatic test_halted();
        write_reg(CFG_BLOCK_LIMIT, 9'd0);
        for (int i = 0; i < 4; i++)
            send_req(rand_req(50), 1'($urandom_range(1)));
        write_reg(CFG_DATA_START, 9'd256);
        write_reg(CFG_BLOCK_LIMIT, 9'd256);
        for (int i = 0; i < 4; i++)
            send_req(rand_req(50), 1'($urandom_range(1)));
        write_reg(CFG_DATA_START, 9'd0);
        for (int i = 0; i < 4; i++)
            send_req(rand_req(50), 1'($urandom_range(1)));
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DATA_START;
        cfg_data  = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_window();
        test_deep_file();
        test_exhaustion();
        test_halted();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d requests, %0d results checked; file index reached %0d", requests_sent,
                 results_seen, peak_idx);
        $display("run ended halted=%0d with error code %0d, %0d mismatches", stopped,
                 stop_code, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
src/ibpa_pkg.sv
src/ibpa_map.sv
src/ibpa_scan.sv
src/ibpa_seq.sv
src/inode_block_placement_allocator_top.sv
src/ibpa_checker.sv
test/tb.sv
